>>> sv/assert_macros.svh
// assertion macros used by hsv_to_rgb332
// needs clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: condition");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, expr)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> sv/hsv2rgb_pkg.sv
// constants for the hsv to rgb332 pipeline
// no dependencies
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_W    = 13;
    localparam int SV_W     = 9;
    localparam int FRAC_W   = 10;
    localparam int SEXT_W   = 4;
    localparam int CHROMA_W = 17;
    localparam int PROD_W   = 26;
    localparam int QUOT_W   = 20;

    localparam logic [SV_W-1:0]     UNIT        = 9'd256;
    localparam logic [FRAC_W-1:0]   HUE_SEXTANT = 10'd960;
    localparam logic [HUE_W-1:0]    HUE_FULL    = 13'd5760;

    // hue / 64 / 15 by reciprocal, exact for the 7-bit range
    localparam int                  SEXT_SHIFT  = 12;
    localparam logic [8:0]          SEXT_RECIP  = 9'(((1 << SEXT_SHIFT) + 14) / 15);

    // product / 64 / 15 by reciprocal, exact below 2^20
    localparam int                  RECIP_SHIFT = 24;
    localparam logic [20:0]         RECIP_15    = 21'(((1 << RECIP_SHIFT) + 14) / 15);

    localparam logic [SEXT_W-1:0]   SEXT_RY = 4'd0;
    localparam logic [SEXT_W-1:0]   SEXT_YG = 4'd1;
    localparam logic [SEXT_W-1:0]   SEXT_GC = 4'd2;
    localparam logic [SEXT_W-1:0]   SEXT_CB = 4'd3;
    localparam logic [SEXT_W-1:0]   SEXT_BM = 4'd4;

    localparam logic [2:0]          RG_TOP  = 3'd7;
    localparam logic [1:0]          B_TOP   = 2'd3;

endpackage

`default_nettype wire

>>> sv/hsv_to_rgb332.sv
// hsv to rgb332 colour conversion, five-stage stream pipeline
// depends on hsv2rgb_pkg and assert_macros.svh
//
// Takes one pixel per clock while the output is not stalled and returns its
// colour. Every stage holds its word with a valid bit and its own ready, so
// a stall at the output fills the empty stages first and only then holds the
// input; nothing is dropped or duplicated. The stages are: saturation and
// value limiting with the sextant number, chroma and hue fraction, chroma
// times fraction, division by 960 through a reciprocal multiply, and the
// channel selection with scaling to 3-3-2 bits. There are no registers to set.
`default_nettype none

`include "assert_macros.svh"

module hsv_to_rgb332 (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // hue[12:0], saturation[21:13], value[30:22], zero pad
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata    // color[7:0], red[10:8], green[13:11], blue[15:14]
);

    localparam int HW = hsv2rgb_pkg::HUE_W;
    localparam int SW = hsv2rgb_pkg::SV_W;
    localparam int FW = hsv2rgb_pkg::FRAC_W;
    localparam int KW = hsv2rgb_pkg::SEXT_W;
    localparam int CW = hsv2rgb_pkg::CHROMA_W;
    localparam int PW = hsv2rgb_pkg::PROD_W;
    localparam int QW = hsv2rgb_pkg::QUOT_W;

    function automatic logic [2:0] level_rg(input logic [CW-1:0] part, input logic [CW-1:0] grey);
        logic [CW:0]   sum;
        logic [CW+3:0] scaled;
        logic [4:0]    q;
        sum    = {1'b0, part} + {1'b0, grey};
        scaled = {3'b000, sum} * 21'(hsv2rgb_pkg::RG_TOP);
        q      = scaled[CW+3:16];
        return (q > 5'(hsv2rgb_pkg::RG_TOP)) ? hsv2rgb_pkg::RG_TOP : q[2:0];
    endfunction

    function automatic logic [1:0] level_b(input logic [CW-1:0] part, input logic [CW-1:0] grey);
        logic [CW:0]   sum;
        logic [CW+2:0] scaled;
        logic [3:0]    q;
        sum    = {1'b0, part} + {1'b0, grey};
        scaled = {2'b00, sum} * 20'(hsv2rgb_pkg::B_TOP);
        q      = scaled[CW+2:16];
        return (q > 4'(hsv2rgb_pkg::B_TOP)) ? hsv2rgb_pkg::B_TOP : q[1:0];
    endfunction

    // valid bits and per-stage ready
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // stage 1: limit saturation and value, sextant number
    logic [HW-1:0] hue_in;
    logic [SW-1:0] sat_in, val_in;
    logic [SW-1:0] s1_next, vv1_next;
    logic [15:0]   kprod;
    logic [KW-1:0] k1_next;
    logic [HW-1:0] h1_reg;
    logic [SW-1:0] s1_reg, vv1_reg;
    logic [KW-1:0] k1_reg;

    assign hue_in   = s_tdata[12:0];
    assign sat_in   = s_tdata[21:13];
    assign val_in   = s_tdata[30:22];
    assign s1_next  = (sat_in > hsv2rgb_pkg::UNIT) ? hsv2rgb_pkg::UNIT : sat_in;
    assign vv1_next = (val_in > hsv2rgb_pkg::UNIT) ? hsv2rgb_pkg::UNIT : val_in;
    assign kprod    = {9'd0, hue_in[HW-1:6]} * {7'd0, hsv2rgb_pkg::SEXT_RECIP};
    assign k1_next  = kprod[15:hsv2rgb_pkg::SEXT_SHIFT];

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            h1_reg  <= hue_in;
            s1_reg  <= s1_next;
            vv1_reg <= vv1_next;
            k1_reg  <= k1_next;
        end
    end

    // stage 2: chroma, grey offset, hue fraction
    logic [13:0]   kbase;
    logic [HW-1:0] fdiff;
    logic [FW-1:0] f_frac;
    logic [17:0]   vs_prod;
    logic [CW-1:0] c2_next, m2_next;
    logic [FW-1:0] fsel2_next;
    logic          ok2_next;
    logic [CW-1:0] c2_reg, m2_reg;
    logic [FW-1:0] fsel2_reg;
    logic [KW-1:0] k2_reg;
    logic          ok2_reg;

    assign kbase      = {10'd0, k1_reg} * {4'd0, hsv2rgb_pkg::HUE_SEXTANT};
    assign fdiff      = h1_reg - kbase[HW-1:0];
    assign f_frac     = fdiff[FW-1:0];
    assign fsel2_next = k1_reg[0] ? (hsv2rgb_pkg::HUE_SEXTANT - f_frac) : f_frac;
    assign vs_prod    = {9'd0, vv1_reg} * {9'd0, s1_reg};
    assign c2_next    = vs_prod[CW-1:0];
    assign m2_next    = {vv1_reg, 8'd0} - c2_next;
    assign ok2_next   = h1_reg < hsv2rgb_pkg::HUE_FULL;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            c2_reg    <= c2_next;
            m2_reg    <= m2_next;
            fsel2_reg <= fsel2_next;
            k2_reg    <= k1_reg;
            ok2_reg   <= ok2_next;
        end
    end

    // stage 3: chroma times fraction
    logic [CW+FW-1:0] p3_next;
    logic [PW-1:0]    p3_reg;
    logic [CW-1:0]    c3_reg, m3_reg;
    logic [KW-1:0]    k3_reg;
    logic             ok3_reg;

    assign p3_next = {{FW{1'b0}}, c2_reg} * {{CW{1'b0}}, fsel2_reg};

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            p3_reg  <= p3_next[PW-1:0];
            c3_reg  <= c2_reg;
            m3_reg  <= m2_reg;
            k3_reg  <= k2_reg;
            ok3_reg <= ok2_reg;
        end
    end

    // stage 4: divide by 960 as shift by 6 then reciprocal of 15
    logic [QW-1:0] n4;
    logic [40:0]   q4_prod;
    logic [CW-1:0] x4_reg, c4_reg, m4_reg;
    logic [KW-1:0] k4_reg;
    logic          ok4_reg;

    assign n4      = p3_reg[PW-1:6];
    assign q4_prod = {21'd0, n4} * {20'd0, hsv2rgb_pkg::RECIP_15};

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            x4_reg  <= q4_prod[40:hsv2rgb_pkg::RECIP_SHIFT];
            c4_reg  <= c3_reg;
            m4_reg  <= m3_reg;
            k4_reg  <= k3_reg;
            ok4_reg <= ok3_reg;
        end
    end

    // stage 5: channel roles and 3-3-2 scaling
    logic [CW-1:0] rp, gp, bp;
    logic [2:0]    r5_next, g5_next;
    logic [1:0]    b5_next;
    logic [15:0]   out_reg;

    always_comb
    begin
        rp = '0;
        gp = '0;
        bp = '0;
        if (ok4_reg)
        begin
            case (k4_reg)
                hsv2rgb_pkg::SEXT_RY: begin rp = c4_reg; gp = x4_reg; end
                hsv2rgb_pkg::SEXT_YG: begin rp = x4_reg; gp = c4_reg; end
                hsv2rgb_pkg::SEXT_GC: begin gp = c4_reg; bp = x4_reg; end
                hsv2rgb_pkg::SEXT_CB: begin gp = x4_reg; bp = c4_reg; end
                hsv2rgb_pkg::SEXT_BM: begin rp = x4_reg; bp = c4_reg; end
                default:              begin rp = c4_reg; bp = x4_reg; end
            endcase
        end
    end

    assign r5_next = level_rg(rp, m4_reg);
    assign g5_next = level_rg(gp, m4_reg);
    assign b5_next = level_b(bp, m4_reg);

    always_ff @(posedge clk)
    begin
        if (rdy5)
            out_reg <= {b5_next, g5_next, r5_next, r5_next, g5_next, b5_next};
    end

    assign m_tdata = out_reg;

    `ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, v1_reg)
    `ASSERT_ALWAYS(a_stall_full, s_tready || (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg))
    `ASSERT_ALWAYS(a_grey_bound, !v2_reg || ({1'b0, c2_reg} + {1'b0, m2_reg} <= 18'd65536))
    `ASSERT_ALWAYS(a_x_le_c, !v4_reg || (x4_reg <= c4_reg))
    `ASSERT_ALWAYS(a_pack, !m_tvalid || (m_tdata[7:0] == {m_tdata[10:8], m_tdata[13:11], m_tdata[15:14]}))

endmodule

`default_nettype wire
